FILE: hdl/hbq_pkg.sv
// hbq_pkg: shared types and constants for the high-pass biquad coefficient block
// no dependencies
`default_nettype none
package hbq_pkg;
   localparam int CORDIC_STEPS = 30;
   localparam logic [31:0] PI_Q30 = 32'd3373259426;
   localparam logic [30:0] SQRT2_Q30 = 31'd1518500250;

   function automatic logic [29:0] atan_q30(input int i);
      logic [29:0] t;
      case (i)
         0: t = 30'd843314857;
         1: t = 30'd497837829;
         2: t = 30'd263043837;
         3: t = 30'd133525159;
         4: t = 30'd67021687;
         5: t = 30'd33543516;
         6: t = 30'd16775851;
         7: t = 30'd8388437;
         8: t = 30'd4194283;
         9: t = 30'd2097149;
         default: t = 30'(32'd1 << (30 - i));
      endcase
      return t;
   endfunction
endpackage
`default_nettype wire

FILE: hdl/hbq_cordic_cell.sv
// hbq_cordic_cell: one rotation step of the tangent chain plus one registered stage
// uses hbq_pkg
`default_nettype none
module hbq_cordic_cell #(
   parameter int STEP = 0
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               valid_in,
   input  wire logic signed [33:0] x_in_w,
   input  wire logic signed [33:0] y_in_w,
   input  wire logic signed [32:0] z_in_w,
   output logic                    valid_ff,
   output logic signed [33:0]      x_ff,
   output logic signed [33:0]      y_ff,
   output logic signed [32:0]      z_ff
);
   logic signed [33:0] x_in, y_in;
   logic signed [32:0] z_in;
   logic signed [32:0] ang;

   always_comb begin
      ang = signed'({3'b000, hbq_pkg::atan_q30(STEP)});
      if (!z_in_w[32]) begin
         x_in = x_in_w - (y_in_w >>> STEP);
         y_in = y_in_w + (x_in_w >>> STEP);
         z_in = z_in_w - ang;
      end else begin
         x_in = x_in_w + (y_in_w >>> STEP);
         y_in = y_in_w - (x_in_w >>> STEP);
         z_in = z_in_w + ang;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end
endmodule
`default_nettype wire

FILE: hdl/hbq_div_cell.sv
// hbq_div_cell: one restoring-division bit step with payload carried alongside
// no dependencies
`default_nettype none
module hbq_div_cell #(
   parameter int NW = 49,
   parameter int DW = 34,
   parameter int QW = 32,
   parameter int PW = 1
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          valid_in,
   input  wire logic [NW-1:0] rem_in_w,
   input  wire logic [NW-1:0] num_in_w,
   input  wire logic [DW-1:0] den_in_w,
   input  wire logic [QW-1:0] quo_in_w,
   input  wire logic [PW-1:0] pay_in_w,
   output logic               valid_ff,
   output logic [NW-1:0]      rem_ff,
   output logic [NW-1:0]      num_ff,
   output logic [DW-1:0]      den_ff,
   output logic [QW-1:0]      quo_ff,
   output logic [PW-1:0]      pay_ff
);
   logic [NW:0] sh;
   logic        ge;
   logic [NW-1:0] rem_in;

   always_comb begin
      sh = {rem_in_w, num_in_w[NW-1]};
      ge = sh >= (NW+1)'(den_in_w);
      rem_in = ge ? NW'(sh - (NW+1)'(den_in_w)) : sh[NW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
      rem_ff <= rem_in;
      num_ff <= {num_in_w[NW-2:0], 1'b0};
      den_ff <= den_in_w;
      quo_ff <= {quo_in_w[QW-2:0], ge};
      pay_ff <= pay_in_w;
   end
endmodule
`default_nettype wire

FILE: hdl/highpass_biquad_coefficients.sv
// highpass_biquad_coefficients: top level, butterworth high-pass biquad coefficients
// uses hbq_pkg, hbq_div_cell, hbq_cordic_cell
`default_nettype none
// A new sample rate / cutoff pair may be started every cycle (busy is always
// low); each transfer yields exactly one result on rsp_strobe. The pipe is
// built from four chains of cells: a 32-step ratio divider, a 30-step
// cordic rotation, a 32-step divider for k = y/x and a 25-step divider for
// 1/d, plus seven single register stages (input, theta, k flags, k select,
// products, d and numerators, scaling) and the output register: 127
// register stages in all between the request transfer and rsp_strobe. The
// receiver cannot stall, so results simply fall out of the pipe. Invalid
// inputs (zero rate or cutoff at or above half the rate) give status 1 and
// zero coefficients.
module highpass_biquad_coefficients #(
   parameter int COEF_FRAC_BITS = 12
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [17:0]        req_sample_rate,
   input  wire logic [16:0]        req_cutoff_freq,
   output logic                    rsp_strobe,
   output logic [12:0]             rsp_b0_coef,
   output logic signed [13:0]      rsp_b1_coef,
   output logic [12:0]             rsp_b2_coef,
   output logic signed [14:0]      rsp_a1_coef,
   output logic signed [12:0]      rsp_a2_coef,
   output logic                    rsp_status
);
   localparam int SH = 48 - COEF_FRAC_BITS;

   assign busy = 1'b0;

   // ---- stage 0: input register, invalid check
   logic        v0_ff, bad0_ff;
   logic [16:0] fc0_ff;
   logic [17:0] fs0_ff;
   always_ff @(posedge clock) begin
      if (reset) v0_ff <= 1'b0;
      else v0_ff <= start;
      fc0_ff  <= req_cutoff_freq;
      fs0_ff  <= req_sample_rate;
      bad0_ff <= (req_sample_rate == 18'd0) ||
                 ({req_cutoff_freq, 1'b0} >= req_sample_rate);
   end

   // ---- ratio divider: r = floor(fc*2^32/fs), 32 quotient bits
   // numerator fc*2^32 has 49 bits; fc < fs so top 17 bits never give a quotient
   // bit, preload remainder with fc and shift 32 zero bits
   localparam int RN = 32;
   logic [RN:0]       rv;
   logic [18:0]       rrem [RN+1];
   logic [31:0]       rnum [RN+1];
   logic [17:0]       rden [RN+1];
   logic [31:0]       rquo [RN+1];
   logic [0:0]        rpay [RN+1];
   logic [31:0]       rrem_w [RN];
   assign rv[0]   = v0_ff;
   assign rrem[0] = bad0_ff ? 19'd0 : {2'b00, fc0_ff};
   assign rnum[0] = 32'd0;
   assign rden[0] = bad0_ff ? 18'd1 : fs0_ff;
   assign rquo[0] = 32'd0;
   assign rpay[0] = bad0_ff;
   for (genvar g = 0; g < RN; g++) begin : g_rdiv
      hbq_div_cell #(.NW(32), .DW(18), .QW(32), .PW(1)) u_cell (
         .clock, .reset, .valid_in(rv[g]),
         .rem_in_w({13'd0, rrem[g]}), .num_in_w(rnum[g]), .den_in_w(rden[g]),
         .quo_in_w(rquo[g]), .pay_in_w(rpay[g]),
         .valid_ff(rv[g+1]), .rem_ff(rrem_w[g]), .num_ff(rnum[g+1]),
         .den_ff(rden[g+1]), .quo_ff(rquo[g+1]), .pay_ff(rpay[g+1]));
      assign rrem[g+1] = rrem_w[g][18:0];
   end

   // ---- theta = (r * PI_Q30) >> 32
   logic        v1_ff, bad1_ff;
   logic [63:0] prod1_ff;
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else v1_ff <= rv[RN];
      prod1_ff <= rquo[RN] * hbq_pkg::PI_Q30;
      bad1_ff  <= rpay[RN][0];
   end

   // ---- cordic chain
   localparam int CN = hbq_pkg::CORDIC_STEPS;
   logic [CN:0]        cv;
   logic signed [33:0] cx [CN+1];
   logic signed [33:0] cy [CN+1];
   logic signed [32:0] cz [CN+1];
   logic [CN:0]        cbad;
   assign cv[0] = v1_ff;
   assign cx[0] = 34'sd1073741824;
   assign cy[0] = '0;
   assign cz[0] = signed'({1'b0, prod1_ff[63:32]});
   assign cbad[0] = bad1_ff;
   for (genvar g = 0; g < CN; g++) begin : g_cordic
      hbq_cordic_cell #(.STEP(g)) u_cell (
         .clock, .reset, .valid_in(cv[g]),
         .x_in_w(cx[g]), .y_in_w(cy[g]), .z_in_w(cz[g]),
         .valid_ff(cv[g+1]), .x_ff(cx[g+1]), .y_ff(cy[g+1]), .z_ff(cz[g+1]));
      always_ff @(posedge clock) cbad[g+1] <= cbad[g];
   end

   // ---- k = floor(y*2^24/x) with saturation; y < 256x, so 32 bits of quotient
   // flags: [2] bad, [1] zero, [0] saturate
   logic        v2_ff;
   logic [2:0]  fl2_ff;
   logic [32:0] y2_ff, x2_ff;
   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else v2_ff <= cv[CN];
      fl2_ff[2] <= cbad[CN];
      fl2_ff[1] <= (cy[CN] <= 0);
      fl2_ff[0] <= (cx[CN] <= 0) || (42'(cy[CN]) >= (42'(cx[CN]) <<< 8));
      y2_ff <= cy[CN][32:0];
      x2_ff <= (cx[CN] > 0) ? cx[CN][32:0] : 33'd1;
   end
   // numerator y*2^24: preload the remainder with y[32:8] (< x), then shift in
   // y[7:0] and 24 zeros for 32 quotient bits
   localparam int KN = 32;
   logic [KN:0]  kv;
   logic [33:0]  krem [KN+1];
   logic [31:0]  knum [KN+1];
   logic [32:0]  kden [KN+1];
   logic [31:0]  kquo [KN+1];
   logic [2:0]   kpay [KN+1];
   logic [33:0]  krem_w [KN];
   logic [33:0]  knum_w [KN];
   assign kv[0]   = v2_ff;
   assign krem[0] = {9'd0, y2_ff[32:8]};
   assign knum[0] = {y2_ff[7:0], 24'd0};
   assign kden[0] = x2_ff;
   assign kquo[0] = 32'd0;
   assign kpay[0] = fl2_ff;
   for (genvar g = 0; g < KN; g++) begin : g_kdiv
      hbq_div_cell #(.NW(34), .DW(33), .QW(32), .PW(3)) u_cell (
         .clock, .reset, .valid_in(kv[g]),
         .rem_in_w(krem[g]), .num_in_w({knum[g], 2'b00}), .den_in_w(kden[g]),
         .quo_in_w(kquo[g]), .pay_in_w(kpay[g]),
         .valid_ff(kv[g+1]), .rem_ff(krem_w[g]), .num_ff(knum_w[g]),
         .den_ff(kden[g+1]), .quo_ff(kquo[g+1]), .pay_ff(kpay[g+1]));
      assign krem[g+1] = krem_w[g];
      assign knum[g+1] = knum_w[g][33:2];
   end

   // ---- k select, then k^2 and sqrt2*k
   logic        v3_ff, bad3_ff;
   logic [31:0] k3_ff;
   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else v3_ff <= kv[KN];
      bad3_ff <= kpay[KN][2];
      k3_ff <= kpay[KN][1] ? 32'd0 : (kpay[KN][0] ? 32'hFFFF_FFFF : kquo[KN]);
   end
   logic        v4_ff, bad4_ff;
   logic [63:0] kk4_ff;
   logic [62:0] sk4_ff;
   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else v4_ff <= v3_ff;
      bad4_ff <= bad3_ff;
      kk4_ff <= k3_ff * k3_ff;
      sk4_ff <= k3_ff * hbq_pkg::SQRT2_Q30;
   end
   // d and the two numerators
   logic        v5_ff, bad5_ff;
   logic [41:0] d5_ff;
   logic signed [42:0] n1_5_ff, n2_5_ff;
   logic [39:0] k2w;
   logic [32:0] skw;
   always_comb begin
      k2w = kk4_ff[63:24];
      skw = sk4_ff[62:30];
   end
   always_ff @(posedge clock) begin
      if (reset) v5_ff <= 1'b0;
      else v5_ff <= v4_ff;
      bad5_ff <= bad4_ff;
      d5_ff   <= 42'(k2w) + 42'(skw) + 42'd16777216;
      n1_5_ff <= 43'sd33554432 - signed'({2'b00, k2w, 1'b0});
      n2_5_ff <= signed'({3'b000, k2w}) - signed'({10'd0, skw}) + 43'sd16777216;
   end

   // ---- inv = floor(2^48/d); d >= 2^24 so the quotient is at most 2^24, 25 bits
   // preload rem = 2^23 (< d) and shift in 25 zeros: numerator 2^23 * 2^25
   localparam int IN = 25;
   logic [IN:0]  iv;
   logic [42:0]  irem [IN+1];
   logic [24:0]  inum [IN+1];
   logic [41:0]  iden [IN+1];
   logic [24:0]  iquo [IN+1];
   logic [86:0]  ipay [IN+1];
   logic [42:0]  irem_w [IN];
   logic [42:0]  inum_w2 [IN];
   assign iv[0]   = v5_ff;
   assign irem[0] = 43'd8388608;
   assign inum[0] = 25'd0;
   assign iden[0] = d5_ff;
   assign iquo[0] = 25'd0;
   assign ipay[0] = {bad5_ff, n1_5_ff, n2_5_ff};
   for (genvar g = 0; g < IN; g++) begin : g_idiv
      hbq_div_cell #(.NW(43), .DW(42), .QW(25), .PW(87)) u_cell (
         .clock, .reset, .valid_in(iv[g]),
         .rem_in_w(irem[g]), .num_in_w({18'd0, inum[g]}), .den_in_w(iden[g]),
         .quo_in_w(iquo[g]), .pay_in_w(ipay[g]),
         .valid_ff(iv[g+1]), .rem_ff(irem_w[g]), .num_ff(inum_w2[g]),
         .den_ff(iden[g+1]), .quo_ff(iquo[g+1]), .pay_ff(ipay[g+1]));
      assign irem[g+1] = irem_w[g];
      assign inum[g+1] = inum_w2[g][24:0];
   end

   // ---- scale: magnitudes times inv, split in high and low halves
   logic [24:0] inv;
   logic        bad6;
   logic signed [42:0] n1, n2;
   assign inv = iquo[IN];
   assign {bad6, n1, n2} = ipay[IN];
   logic        v7_ff, bad7_ff, s1_7_ff, s2_7_ff;
   logic [45:0] m1h_7_ff, m1l_7_ff, m2h_7_ff, m2l_7_ff;
   logic [24:0] inv7_ff;
   logic [42:0] a1m, a2m;
   always_comb begin
      a1m = n1[42] ? 43'(-n1) : 43'(n1);
      a2m = n2[42] ? 43'(-n2) : 43'(n2);
   end
   always_ff @(posedge clock) begin
      if (reset) v7_ff <= 1'b0;
      else v7_ff <= iv[IN];
      bad7_ff <= bad6;
      s1_7_ff <= n1[42];
      s2_7_ff <= n2[42];
      m1h_7_ff <= a1m[41:21] * inv;
      m1l_7_ff <= a1m[20:0] * inv;
      m2h_7_ff <= a2m[41:21] * inv;
      m2l_7_ff <= a2m[20:0] * inv;
      inv7_ff <= inv;
   end

   // ---- output register
   logic [66:0] q1, q2;
   logic [39:0] b0w;
   always_comb begin
      q1  = ((67'(m1h_7_ff) << 21) + 67'(m1l_7_ff)) >> SH;
      q2  = ((67'(m2h_7_ff) << 21) + 67'(m2l_7_ff)) >> SH;
      b0w = (40'(inv7_ff) << COEF_FRAC_BITS) >> 24;
   end
   always_ff @(posedge clock) begin
      if (reset) rsp_strobe <= 1'b0;
      else rsp_strobe <= v7_ff;
      rsp_status  <= bad7_ff;
      rsp_b0_coef <= bad7_ff ? 13'd0 : b0w[12:0];
      rsp_b2_coef <= bad7_ff ? 13'd0 : b0w[12:0];
      rsp_b1_coef <= bad7_ff ? 14'sd0 : 14'(-{b0w[12:0], 1'b0});
      rsp_a1_coef <= bad7_ff ? 15'sd0 : (s1_7_ff ? 15'(-q1[14:0]) : q1[14:0]);
      rsp_a2_coef <= bad7_ff ? 13'sd0 : (s2_7_ff ? q2[12:0] : 13'(-q2[12:0]));
   end

   // ---- checks
   a_busy_low: assert property (@(posedge clock) busy == 1'b0)
      else $error("busy raised");
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status |-> rsp_b0_coef == 13'd0 && rsp_a1_coef == 15'sd0)
      else $error("invalid result carries coefficients");
   a_b1_match: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_b1_coef == 14'(-{rsp_b0_coef, 1'b0}))
      else $error("b1 not minus twice b0");
endmodule
`default_nettype wire
